@@ sv/ibfr_pkg.sv @@
// ibfr_pkg: shared types and constants for the ibus frame receiver
// no dependencies; used by the interfaces, the cell, the parser and the top level
package ibfr_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int POS_W    = 5;
   localparam int CH_IDX_W = 4;

   localparam logic [BYTE_W-1:0] HDR_LO   = 8'h20;
   localparam logic [BYTE_W-1:0] HDR_HI   = 8'h40;
   localparam logic [WORD_W-1:0] HDR_WORD = 16'h4020;
   localparam logic [WORD_W-1:0] SUM_INIT = 16'hFFFF - HDR_WORD;

   // control handed to every cell of the channel row
   typedef struct packed {
      logic shift;   // a new channel word enters the capture row
      logic load;    // frame complete: capture row copied to output row
      logic pop;     // head result taken: output row moves one place
   } ibfr_cell_ctrl_type;

   // events from the byte parser
   typedef struct packed {
      logic word_valid;
      logic frame_done;
      logic frame_good;
      logic at_checksum;
   } ibfr_evt_type;

endpackage

@@ sv/ibfr_req_if.sv @@
// ibfr_req_if: request channel carrying one received byte
// depends on ibfr_pkg
interface ibfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [ibfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/ibfr_rsp_if.sv @@
// ibfr_rsp_if: result channel carrying one decoded channel value
// depends on ibfr_pkg
interface ibfr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ibfr_pkg::CH_IDX_W-1:0]  channel_index;
   logic [ibfr_pkg::WORD_W-1:0]    channel_value;
   logic                           frame_good;
   logic                           last_channel;

   modport source (output valid, output channel_index, output channel_value,
                   output frame_good, output last_channel, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input frame_good, input last_channel, output ready);
endinterface

@@ sv/ibfr_cell.sv @@
// ibfr_cell: one cell of the channel row, a capture word and an output word
// depends on ibfr_pkg
module ibfr_cell (
   input  logic                        clock,
   input  ibfr_pkg::ibfr_cell_ctrl_type ctrl,
   input  logic [ibfr_pkg::WORD_W-1:0] cap_prev,
   input  logic [ibfr_pkg::WORD_W-1:0] out_upstream,
   output logic [ibfr_pkg::WORD_W-1:0] cap_word,
   output logic [ibfr_pkg::WORD_W-1:0] out_word
);
   import ibfr_pkg::*;

   logic [WORD_W-1:0] cap_ff, cap_in;
   logic [WORD_W-1:0] out_ff, out_in;

   always_comb begin
      cap_in = ctrl.shift ? cap_prev : cap_ff;
      if (ctrl.load) begin
         out_in = cap_ff;
      end else if (ctrl.pop) begin
         out_in = out_upstream;
      end else begin
         out_in = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
      out_ff <= out_in;
   end

   assign cap_word = cap_ff;
   assign out_word = out_ff;

endmodule

@@ sv/ibfr_parse.sv @@
// ibfr_parse: header hunt, word assembly and checksum for the byte stream
// depends on ibfr_pkg
module ibfr_parse #(
   parameter int NUM_CHANNELS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [ibfr_pkg::BYTE_W-1:0] rx_byte,
   output logic [ibfr_pkg::WORD_W-1:0] word,
   output ibfr_pkg::ibfr_evt_type      evt
);
   import ibfr_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_GOT_LO,
      PH_PAYLOAD
   } phase_type;

   localparam logic [CH_IDX_W-1:0] CK_IDX = CH_IDX_W'(NUM_CHANNELS);

   phase_type         phase_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0] sum_ff;
   logic [BYTE_W-1:0] low_ff;
   logic              ck_pos;

   assign word   = {rx_byte, low_ff};
   // high byte of the word after the last channel is the checksum
   assign ck_pos = (phase_ff == PH_PAYLOAD) && pos_ff[0] && (pos_ff[POS_W-1:1] == CK_IDX);

   always_comb begin
      evt.word_valid  = accept && (phase_ff == PH_PAYLOAD) && pos_ff[0] && !ck_pos;
      evt.frame_done  = accept && ck_pos;
      evt.frame_good  = (sum_ff == word);
      evt.at_checksum = ck_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         sum_ff   <= '0;
         low_ff   <= '0;
      end else if (accept) begin
         case (phase_ff)
            PH_GOT_LO: begin
               if (rx_byte == HDR_HI) begin
                  phase_ff <= PH_PAYLOAD;
                  pos_ff   <= '0;
                  sum_ff   <= SUM_INIT;
               end else if (rx_byte != HDR_LO) begin
                  phase_ff <= PH_HUNT;
               end
            end
            PH_PAYLOAD: begin
               if (!pos_ff[0]) begin
                  low_ff <= rx_byte;
                  pos_ff <= pos_ff + POS_W'(1);
               end else if (!ck_pos) begin
                  sum_ff <= sum_ff - word;
                  pos_ff <= pos_ff + POS_W'(1);
               end else begin
                  phase_ff <= PH_HUNT;
                  pos_ff   <= '0;
                  sum_ff   <= '0;
                  low_ff   <= '0;
               end
            end
            default: begin
               phase_ff <= (rx_byte == HDR_LO) ? PH_GOT_LO : PH_HUNT;
            end
         endcase
      end
   end

endmodule

@@ sv/ibus_frame_receiver_top.sv @@
// ibus_frame_receiver_top: ibus frame decoder built on a row of channel cells
// depends on ibfr_pkg, ibfr_req_if, ibfr_rsp_if, ibfr_parse, ibfr_cell
//
// Usage:
//   req_chan carries one received byte per request. The block hunts for the
//   header 0x20 0x40, then takes NUM_CHANNELS little-endian channel words and
//   a checksum word. Each channel word shifts into a row of cells as it
//   completes; the checksum byte copies the row into the output side of the
//   cells, which then drains one result per cycle on rsp_chan when it is ready,
//   channel 0 first, frame_good on every result and last_channel on the final
//   one. Throughput: one byte per cycle while req_chan.ready is high. The
//   first result is valid the cycle after the checksum high byte is taken;
//   a frame drains while the next frame's bytes keep arriving.
//   req_chan.ready drops only when a checksum byte is due while the previous
//   frame's results are still waiting in the output row (rsp_chan stalled);
//   every other byte is taken at once.
//   Reset (synchronous) returns to header hunting and drops the results in the
//   output row; a frame in progress is dropped.
module ibus_frame_receiver_top #(
   parameter int NUM_CHANNELS = 14
) (
   input  logic       clock,
   input  logic       reset,
   ibfr_req_if.sink   req_chan,
   ibfr_rsp_if.source rsp_chan
);
   import ibfr_pkg::*;

   localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(NUM_CHANNELS - 1);

   logic               req_accept;
   logic               rsp_pop;
   logic [WORD_W-1:0]  new_word;
   ibfr_evt_type       evt;
   ibfr_cell_ctrl_type cell_ctrl;

   logic [WORD_W-1:0]   cap_word [NUM_CHANNELS];
   logic [WORD_W-1:0]   out_word [NUM_CHANNELS];

   logic                busy_ff;
   logic                good_ff;
   logic [CH_IDX_W-1:0] idx_ff;

   assign req_chan.ready = !(evt.at_checksum && busy_ff);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_pop        = busy_ff && rsp_chan.ready;

   ibfr_parse #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_chan.rx_byte),
      .word    (new_word),
      .evt     (evt)
   );

   always_comb begin
      cell_ctrl.shift = evt.word_valid;
      cell_ctrl.load  = evt.frame_done;
      cell_ctrl.pop   = rsp_pop;
   end

   // capture row fills from the tail so channel 0 ends in cell 0, the output head
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
      logic [WORD_W-1:0] cap_src;
      logic [WORD_W-1:0] out_src;

      if (i == NUM_CHANNELS - 1) begin : g_tail
         assign cap_src = new_word;
         assign out_src = '0;
      end else begin : g_body
         assign cap_src = cap_word[i+1];
         assign out_src = out_word[i+1];
      end

      ibfr_cell u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .cap_prev     (cap_src),
         .out_upstream (out_src),
         .cap_word     (cap_word[i]),
         .out_word     (out_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         good_ff <= 1'b0;
      end else if (evt.frame_done) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         good_ff <= evt.frame_good;
      end else if (rsp_pop) begin
         idx_ff <= idx_ff + CH_IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid         = busy_ff;
   assign rsp_chan.channel_index = idx_ff;
   assign rsp_chan.channel_value = out_word[0];
   assign rsp_chan.frame_good    = good_ff;
   assign rsp_chan.last_channel  = (idx_ff == LAST_IDX);

endmodule
